// ===== rtl/periodic_shape_voxel_pattern_top_assert.svh =====
// Assertion macros for the periodic shape voxel pattern block.
// Included by the top level; depends on nothing else.
`ifndef PERIODIC_SHAPE_VOXEL_PATTERN_TOP_ASSERT_SVH
`define PERIODIC_SHAPE_VOXEL_PATTERN_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define PSVP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define PSVP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/psvp_pkg.sv =====
// Shared constants and types for the periodic shape voxel pattern block.
// No dependencies.
package psvp_pkg;

  localparam int MAX_EDGE_DEF  = 256;
  localparam int MAX_LEVEL_DEF = 16;
  localparam int EDGE_RST      = 64;
  // Conditional doublings done per modulo stage
  localparam int DBL_PER_STAGE = 4;

  localparam logic [7:0] VAL_INSIDE  = 8'hFF;
  localparam logic [7:0] VAL_OUTSIDE = 8'h00;

  typedef enum logic [1:0] {
    REG_EDGE  = 2'd0,
    REG_LEVEL = 2'd1,
    REG_MODE  = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_SPHERE = 1'b0,
    MODE_TORUS  = 1'b1
  } shape_mode_t;

endpackage

// ===== rtl/psvp_mod_pipe.sv =====
// Pipelined (index << level) mod N for three axes, by repeated doubling.
// Depends on psvp_pkg.
module psvp_mod_pipe import psvp_pkg::*; #(
  parameter int MAX_EDGE  = MAX_EDGE_DEF,
  parameter int MAX_LEVEL = MAX_LEVEL_DEF,
  localparam int EW  = $clog2(MAX_EDGE + 1),
  localparam int LVW = (MAX_LEVEL > 0) ? $clog2(MAX_LEVEL + 1) : 1
) (
  input  logic           clk,
  input  logic           en,
  input  logic [EW-1:0]  edge_n,
  input  logic [LVW-1:0] level,
  input  logic [7:0]     in_x,
  input  logic [7:0]     in_y,
  input  logic [7:0]     in_z,
  output logic [EW-1:0]  r_x,
  output logic [EW-1:0]  r_y,
  output logic [EW-1:0]  r_z
);

  localparam int NST = (MAX_LEVEL == 0) ? 1 :
                       (MAX_LEVEL + DBL_PER_STAGE - 1) / DBL_PER_STAGE;

  logic [EW-1:0] r_r [NST][3];

  // One doubling mod N; input is below N, so one subtract suffices
  function automatic logic [EW-1:0] dbl_mod(input logic [EW-1:0] r,
                                            input logic [EW-1:0] n);
    logic [EW:0] t;
    begin
      t = {r, 1'b0};
      if (t >= {1'b0, n}) t = t - {1'b0, n};
      return t[EW-1:0];
    end
  endfunction

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [EW-1:0] src   [3];
    logic [EW-1:0] r_nxt [3];

    if (s == 0) begin : g_first
      assign src[0] = EW'(in_x);
      assign src[1] = EW'(in_y);
      assign src[2] = EW'(in_z);
    end else begin : g_rest
      assign src[0] = r_r[s-1][0];
      assign src[1] = r_r[s-1][1];
      assign src[2] = r_r[s-1][2];
    end

    // Apply this stage's share of the level doublings
    always_comb begin
      for (int a = 0; a < 3; a++) begin
        r_nxt[a] = src[a];
        for (int j = 0; j < DBL_PER_STAGE; j++) begin
          if (s * DBL_PER_STAGE + j < int'(level)) r_nxt[a] = dbl_mod(r_nxt[a], edge_n);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int a = 0; a < 3; a++) r_r[s][a] <= r_nxt[a];
      end
    end
  end

  assign r_x = r_r[NST-1][0];
  assign r_y = r_r[NST-1][1];
  assign r_z = r_r[NST-1][2];

endmodule

// ===== rtl/periodic_shape_voxel_pattern_top.sv =====
// Top level of the periodic shape voxel pattern block: config registers,
// shape test and address pipeline. Depends on psvp_pkg, psvp_mod_pipe and the assert header.
//
//   channel  ports                               direction
//   in       in_valid/in_ready, in_voxel_x/y/z   word in
//   out      out_valid/out_ready, out_voxel_*    word out
//   cfg      cfg_we, cfg_index, cfg_data         register write
//
// One word enters per cycle unless the output stalls; the pipe is ceil(MAX_LEVEL/4)
// modulo stages, set by the doubling chain, plus four shape stages.
// All stages move on one enable: out_ready low with a word waiting holds
// the whole pipe, nothing dropped or repeated.
// Reset is synchronous and clears valid bits and config registers only.
module periodic_shape_voxel_pattern_top import psvp_pkg::*; #(
  parameter int MAX_EDGE  = MAX_EDGE_DEF,
  parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_voxel_x,
  input  logic [7:0]  in_voxel_y,
  input  logic [7:0]  in_voxel_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_voxel_value,
  output logic [23:0] out_voxel_address,
  output logic        out_index_out_of_range,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  `include "periodic_shape_voxel_pattern_top_assert.svh"

  localparam int EW   = $clog2(MAX_EDGE + 1);
  localparam int LVW  = (MAX_LEVEL > 0) ? $clog2(MAX_LEVEL + 1) : 1;
  localparam int NST  = (MAX_LEVEL == 0) ? 1 :
                        (MAX_LEVEL + DBL_PER_STAGE - 1) / DBL_PER_STAGE;
  localparam int SQW  = 2 * EW;
  localparam int SW   = SQW + 2;
  localparam int LLW  = SQW + 9;
  localparam int NQW  = 2 * SQW + 1;
  localparam int MW   = NQW + 14;
  localparam int ERST = (EDGE_RST > MAX_EDGE) ? MAX_EDGE : EDGE_RST;

  // Config registers
  logic [EW-1:0]  edge_r;
  logic [LVW-1:0] level_r;
  shape_mode_t    mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r  <= EW'(ERST);
      level_r <= '0;
      mode_r  <= MODE_SPHERE;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_EDGE: begin
          if (int'(cfg_data) > MAX_EDGE) edge_r <= EW'(MAX_EDGE);
          else edge_r <= EW'(cfg_data);
        end
        REG_LEVEL: begin
          if (int'(cfg_data[4:0]) > MAX_LEVEL) level_r <= LVW'(MAX_LEVEL);
          else level_r <= LVW'(cfg_data[4:0]);
        end
        REG_MODE: mode_r <= shape_mode_t'(cfg_data[0]);
        default: ;
      endcase
    end
  end

  // Global advance: move when the output slot is free or being taken
  logic en;
  logic p4_v_r;
  assign en       = !p4_v_r || out_ready;
  assign in_ready = en;

  // Modulo stages; side data travels alongside
  logic [EW-1:0] rx, ry, rz;
  psvp_mod_pipe #(.MAX_EDGE(MAX_EDGE), .MAX_LEVEL(MAX_LEVEL)) u_mod (
    .clk(clk), .en(en), .edge_n(edge_r), .level(level_r),
    .in_x(in_voxel_x), .in_y(in_voxel_y), .in_z(in_voxel_z),
    .r_x(rx), .r_y(ry), .r_z(rz)
  );

  logic       m_v_r   [NST];
  logic       m_oor_r [NST];
  logic [7:0] m_x_r   [NST];
  logic [7:0] m_y_r   [NST];
  logic [7:0] m_z_r   [NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) m_v_r[s] <= 1'b0;
    end else if (en) begin
      m_v_r[0] <= in_valid;
      for (int s = 1; s < NST; s++) m_v_r[s] <= m_v_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_oor_r[0] <= (in_voxel_x >= edge_r) || (in_voxel_y >= edge_r) ||
                    (in_voxel_z >= edge_r);
      m_x_r[0]   <= in_voxel_x;
      m_y_r[0]   <= in_voxel_y;
      m_z_r[0]   <= in_voxel_z;
      for (int s = 1; s < NST; s++) begin
        m_oor_r[s] <= m_oor_r[s-1];
        m_x_r[s]   <= m_x_r[s-1];
        m_y_r[s]   <= m_y_r[s-1];
        m_z_r[s]   <= m_z_r[s-1];
      end
    end
  end

  // Stage 1: centered offsets squared, N^2, x cut, z*N
  logic signed [EW+1:0]  a_c, b_c, c_c;
  logic signed [SQW-1:0] a_w, b_w, c_w;
  logic [EW+2:0]         rx5, n3;
  assign a_c = $signed({1'b0, rx, 1'b0}) - $signed({2'b00, edge_r});
  assign b_c = $signed({1'b0, ry, 1'b0}) - $signed({2'b00, edge_r});
  assign c_c = $signed({1'b0, rz, 1'b0}) - $signed({2'b00, edge_r});
  // Widen before squaring so the product keeps all its bits
  assign a_w = SQW'(a_c);
  assign b_w = SQW'(b_c);
  assign c_w = SQW'(c_c);
  assign rx5 = (EW+3)'({rx, 2'b00}) + (EW+3)'(rx);
  assign n3  = (EW+3)'({edge_r, 1'b0}) + (EW+3)'(edge_r);

  logic           p1_v_r, p1_oor_r, p1_xlt_r;
  logic [SQW-1:0] p1_asq_r, p1_bsq_r, p1_csq_r, p1_nsq_r;
  logic [7:0]     p1_x_r, p1_y_r;
  logic [23:0]    p1_zn_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_oor_r <= m_oor_r[NST-1];
      p1_xlt_r <= rx5 < n3;
      p1_asq_r <= $unsigned(a_w * a_w);
      p1_bsq_r <= $unsigned(b_w * b_w);
      p1_csq_r <= $unsigned(c_w * c_w);
      p1_nsq_r <= SQW'(edge_r) * SQW'(edge_r);
      p1_x_r   <= m_x_r[NST-1];
      p1_y_r   <= m_y_r[NST-1];
      p1_zn_r  <= 24'(m_z_r[NST-1]) * 24'(edge_r);
    end
  end

  // Stage 2: sums, torus left side, N^2*Q, (zN+y)*N
  logic           p2_v_r, p2_oor_r, p2_xlt_r;
  logic [SW-1:0]  p2_s_r;
  logic [SQW-1:0] p2_nsq_r;
  logic [LLW-1:0] p2_l_r;
  logic [NQW-1:0] p2_nq_r;
  logic [7:0]     p2_x_r;
  logic [23:0]    p2_t_r;
  logic [SQW:0]   q_c;
  assign q_c = (SQW+1)'(p1_asq_r) + (SQW+1)'(p1_bsq_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p2_oor_r <= p1_oor_r;
      p2_xlt_r <= p1_xlt_r;
      p2_s_r   <= SW'(q_c) + SW'(p1_csq_r);
      p2_nsq_r <= p1_nsq_r;
      p2_l_r   <= LLW'(p1_nsq_r) * LLW'(21) +
                  LLW'(100) * (LLW'(q_c) + LLW'(p1_csq_r));
      p2_nq_r  <= NQW'(p1_nsq_r) * NQW'(q_c);
      p2_x_r   <= p1_x_r;
      p2_t_r   <= 24'((p1_zn_r + 24'(p1_y_r)) * 24'(edge_r));
    end
  end

  // Stage 3: sphere compare, L^2, 10000*N^2*Q, address
  logic          p3_v_r, p3_oor_r, p3_xlt_r, p3_sph_r, p3_big_r;
  logic [63:0]   p3_ll_r;
  logic [MW-1:0] p3_m_r;
  logic [23:0]   p3_addr_r;
  logic [31:0]   l32;
  assign l32 = 32'(p2_l_r);

  always_ff @(posedge clk) begin
    if (en) begin
      p3_oor_r  <= p2_oor_r;
      p3_xlt_r  <= p2_xlt_r;
      p3_sph_r  <= ((SW+2)'(p2_s_r) << 2) <= (SW+2)'(p2_nsq_r);
      p3_big_r  <= 64'(p2_l_r) >= 64'h1_0000_0000;
      p3_ll_r   <= 64'(l32) * 64'(l32);
      p3_m_r    <= MW'(p2_nq_r) * MW'(10000);
      p3_addr_r <= p2_t_r + 24'(p2_x_r);
    end
  end

  // Stage 4: output register
  logic        inside_c;
  logic [7:0]  p4_val_r;
  logic [23:0] p4_addr_r;
  logic        p4_oor_r;

  always_comb begin
    if (mode_r == MODE_TORUS) inside_c = p3_xlt_r && !p3_big_r && (p3_ll_r <= p3_m_r);
    else inside_c = p3_sph_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4_val_r  <= (!p3_oor_r && inside_c) ? VAL_INSIDE : VAL_OUTSIDE;
      p4_addr_r <= p3_addr_r;
      p4_oor_r  <= p3_oor_r;
    end
  end

  // Valid bits of the shape stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= m_v_r[NST-1];
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
    end
  end

  assign out_valid              = p4_v_r;
  assign out_voxel_value        = p4_val_r;
  assign out_voxel_address      = p4_addr_r;
  assign out_index_out_of_range = p4_oor_r;

  `PSVP_ASSERT_NOW(a_oor_zero, clk, rst_n, out_valid && out_index_out_of_range, out_voxel_value == VAL_OUTSIDE, "out-of-range word carries nonzero value")
  `PSVP_ASSERT_NOW(a_val_code, clk, rst_n, out_valid, out_voxel_value == VAL_INSIDE || out_voxel_value == VAL_OUTSIDE, "value is neither inside nor outside code")
  `PSVP_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_voxel_value) && $stable(out_voxel_address), "output word changed while stalled")
  `PSVP_ASSERT_NOW(a_cfg_clamp, clk, rst_n, 1'b1, int'(edge_r) <= MAX_EDGE && int'(level_r) <= MAX_LEVEL, "config register above its limit")

endmodule

// ===== dv/testbench.sv =====
// Testbench for periodic_shape_voxel_pattern_top: directed and random voxel words
// checked against an in-bench shape classifier. Depends on psvp_pkg and the RTL.
module testbench import psvp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          DRAIN_CYCLES = 24;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  typedef struct packed {
    logic [7:0]  value;
    logic [23:0] address;
    logic        oor;
  } voxel_result_t;

  typedef struct {
    logic [7:0]    x, y, z;
    bit            typed;
    voxel_result_t res;
  } voxel_row_t;

  typedef struct {
    int          edge_val;
    int          level_val;
    shape_mode_t mode_val;
  } cfg_setting_t;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [7:0]  in_voxel_x, in_voxel_y, in_voxel_z;
  logic        out_valid, out_ready;
  logic [7:0]  out_voxel_value;
  logic [23:0] out_voxel_address;
  logic        out_index_out_of_range;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  // Shadow copy of the configuration registers
  int          edge_n;
  int          level_n;
  shape_mode_t mode_n;

  voxel_result_t expected_voxels[$];
  int            fail_count;
  int            cycle_count;
  int            burst_left;

  periodic_shape_voxel_pattern_top u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Exact integer form of the sphere and torus membership tests
  function automatic voxel_result_t classify_voxel(logic [7:0] x, logic [7:0] y,
                                                   logic [7:0] z);
    voxel_result_t r;
    longint n, rx, ry, rz, a, b, c, q, l, m;
    bit hit;
    n = edge_n;
    hit = 1'b0;
    r.address = 24'(((longint'(z) * n + y) * n + x));
    r.oor = (x >= n) || (y >= n) || (z >= n);
    if (!r.oor) begin
      rx = (longint'(x) << level_n) % n;
      ry = (longint'(y) << level_n) % n;
      rz = (longint'(z) << level_n) % n;
      a = 2 * rx - n;
      b = 2 * ry - n;
      c = 2 * rz - n;
      if (mode_n == MODE_SPHERE) begin
        hit = 4 * (a * a + b * b + c * c) <= n * n;
      end else begin
        q = a * a + b * b;
        l = 21 * n * n + 100 * (q + c * c);
        m = 10000 * n * n * q;
        hit = (5 * rx < 3 * n) && (l < (64'd1 << 32)) && (l * l <= m);
      end
    end
    r.value = hit ? VAL_INSIDE : VAL_OUTSIDE;
    return r;
  endfunction

  // Write one register and mirror the clamping into the shadow copy
  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_EDGE:  edge_n  = (data > MAX_EDGE_DEF) ? MAX_EDGE_DEF : int'(data);
      REG_LEVEL: level_n = (data[4:0] > MAX_LEVEL_DEF) ? MAX_LEVEL_DEF : int'(data[4:0]);
      REG_MODE:  mode_n  = shape_mode_t'(data[0]);
      default: ;
    endcase
  endtask

  // Present one word, holding valid across bursts, and queue its expectation
  task automatic send_voxel(voxel_row_t row);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
    end
    in_valid   <= 1'b1;
    in_voxel_x <= row.x;
    in_voxel_y <= row.y;
    in_voxel_z <= row.z;
    expected_voxels.push_back(row.typed ? row.res : classify_voxel(row.x, row.y, row.z));
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_voxels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: alternate between always-ready stretches and random stalls
  initial begin
    int pattern, stretch;
    out_ready = 1'b0;
    forever begin
      pattern = $urandom_range(0, 3);
      stretch = $urandom_range(10, 120);
      repeat (stretch) begin
        @(posedge clk);
        case (pattern)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 1) != 0);
          default: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    voxel_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_voxels.size() == 0) begin
        $error("unexpected result: value %0d address %0d", out_voxel_value,
               out_voxel_address);
        fail_count++;
      end else begin
        exp_r = expected_voxels.pop_front();
        if (out_voxel_value !== exp_r.value) begin
          $error("voxel_value expected %0d actual %0d", exp_r.value, out_voxel_value);
          fail_count++;
        end
        if (out_voxel_address !== exp_r.address) begin
          $error("voxel_address expected %0d actual %0d", exp_r.address,
                 out_voxel_address);
          fail_count++;
        end
        if (out_index_out_of_range !== exp_r.oor) begin
          $error("index_out_of_range expected %0d actual %0d", exp_r.oor,
                 out_index_out_of_range);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[periodic_shape_voxel_pattern_top] ERROR");
      $finish;
    end
  end

  initial begin
    voxel_row_t   directed[$];
    cfg_setting_t phases[$];
    voxel_row_t   row;
    int           n;
    cycle_count = 0;
    fail_count  = 0;
    burst_left  = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_voxel_x  = '0;
    in_voxel_y  = '0;
    in_voxel_z  = '0;
    cfg_we      = 1'b0;
    cfg_index   = REG_EDGE;
    cfg_data    = '0;
    edge_n      = EDGE_RST;
    level_n     = 0;
    mode_n      = MODE_SPHERE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words at the reset configuration (N=64, level 0, sphere)
    directed = '{
      '{8'd0,   8'd0,   8'd0,   1, '{VAL_OUTSIDE, 24'd0,       1'b0}},
      '{8'd32,  8'd32,  8'd32,  1, '{VAL_INSIDE,  24'd133152,  1'b0}},
      '{8'd255, 8'd255, 8'd255, 1, '{VAL_OUTSIDE, 24'd1061055, 1'b1}},
      '{8'd63,  8'd0,   8'd0,   1, '{VAL_OUTSIDE, 24'd63,      1'b0}},
      '{8'd0,   8'd0,   8'd63,  1, '{VAL_OUTSIDE, 24'd258048,  1'b0}},
      '{8'd64,  8'd0,   8'd0,   0, '{default: '0}},
      '{8'd0,   8'd64,  8'd0,   0, '{default: '0}},
      '{8'd0,   8'd0,   8'd64,  0, '{default: '0}},
      '{8'd40,  8'd32,  8'd32,  0, '{default: '0}},
      '{8'd48,  8'd32,  8'd32,  0, '{default: '0}},
      '{8'd32,  8'd48,  8'd16,  0, '{default: '0}},
      '{8'd63,  8'd63,  8'd63,  0, '{default: '0}},
      '{8'd128, 8'd1,   8'd2,   0, '{default: '0}},
      '{8'd170, 8'd85,  8'd255, 0, '{default: '0}}
    };
    foreach (directed[i]) send_voxel(directed[i]);
    drain();

    // Configuration phases, extremes included; writes above range get clamped
    phases = '{
      '{64, 0, MODE_TORUS},  '{0, 3, MODE_SPHERE},  '{1, 0, MODE_SPHERE},
      '{511, 0, MODE_SPHERE}, '{256, 31, MODE_SPHERE}, '{256, 16, MODE_TORUS},
      '{37, 2, MODE_TORUS},  '{200, 5, MODE_SPHERE}, '{100, 1, MODE_TORUS},
      '{255, 4, MODE_TORUS}, '{16, 2, MODE_SPHERE},  '{256, 0, MODE_TORUS}
    };
    foreach (phases[p]) begin
      write_reg(REG_EDGE,  9'(phases[p].edge_val));
      write_reg(REG_LEVEL, 9'(phases[p].level_val));
      write_reg(REG_MODE,  9'(phases[p].mode_val));
      if (p == 6) write_reg(REG_UNUSED, 9'($urandom_range(0, 511)));
      n = edge_n;
      repeat (155) begin
        row.typed = 1'b0;
        row.res   = '0;
        if (n > 0 && $urandom_range(0, 99) < 85) begin
          row.x = 8'($urandom_range(0, n - 1));
          row.y = 8'($urandom_range(0, n - 1));
          row.z = 8'($urandom_range(0, n - 1));
        end else begin
          row.x = 8'($urandom_range(0, 255));
          row.y = 8'($urandom_range(0, 255));
          row.z = 8'($urandom_range(0, 255));
        end
        send_voxel(row);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("[periodic_shape_voxel_pattern_top] OK");
    end else begin
      $display("[periodic_shape_voxel_pattern_top] ERROR");
    end
    $finish;
  end

endmodule
